### rtl/gww_pkg.sv
// Shared types and constants of the greedy word wrap breaker.
package gww_pkg;

  // Field widths of the ports
  localparam int OUT_W   = 10;
  localparam int PIX_W   = 13;
  localparam int VIEW_W  = 12;
  localparam int SPACE_W = 8;
  localparam int BYTE_W  = 8;
  localparam int ADV_W   = 8;
  localparam int CFG_IDX_W = 1;

  // Pixel sums saturate here
  localparam logic [PIX_W-1:0] PIX_MAX = 13'd8191;

  // Byte codes
  localparam logic [BYTE_W-1:0] SPACE_CHAR = 8'h20;
  localparam logic [BYTE_W-1:0] CONT_MASK  = 8'hC0;
  localparam logic [BYTE_W-1:0] CONT_TAG   = 8'h80;

  // Input word kinds
  localparam logic KIND_TEXT = 1'b0;
  localparam logic KIND_EOL  = 1'b1;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_VIEWPORT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_SPACE    = 1'b1;

  // Reset values of the configuration registers
  localparam logic [VIEW_W-1:0]  VIEW_RESET  = 12'd480;
  localparam logic [SPACE_W-1:0] SPACE_RESET = 8'd8;

  // Result queue geometry
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = 2;
  localparam int QCNT_W      = 3;

  // One display line result
  typedef struct packed {
    logic [OUT_W-1:0] start;
    logic [OUT_W-1:0] length;
    logic             last;
  } res_t;

endpackage

### rtl/greedy_word_wrap_breaker.sv
// Greedy word wrap of a source text line into display line offsets and lengths.
//
// Source bytes arrive one word per cycle with their pixel advance, followed by an
// end-of-line word. Each accepted word is folded into the line state in the same
// cycle and can produce up to two display line results, which go into a
// four-entry result queue. A new word is taken every cycle while the queue has
// room for two results (src_stall is high when three or more results wait), so
// the block runs at one source byte per cycle as long as the output side drains
// one result per cycle. Results leave in order, one per cycle while res_stall is low.
// Only the first LINE_BYTES-1 bytes of one source line are kept. Configuration writes
// are taken in any cycle (cfg_ready is always high).
module greedy_word_wrap_breaker #(
  parameter int LINE_BYTES = 1024
) (
  input  logic                          clk,
  input  logic                          rst,
  // source words
  input  logic                          src_valid,
  output logic                          src_stall,
  input  logic                          kind,
  input  logic [gww_pkg::BYTE_W-1:0]    char_byte,
  input  logic [gww_pkg::ADV_W-1:0]     advance,
  // display line results
  output logic                          res_valid,
  input  logic                          res_stall,
  output logic [gww_pkg::OUT_W-1:0]     line_offset,
  output logic [gww_pkg::OUT_W-1:0]     line_length,
  output logic                          last_of_line,
  // configuration writes
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [gww_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]                   cfg_data
);
  import gww_pkg::*;

  localparam int POS_W = $clog2(LINE_BYTES);
  localparam int EXT_W = (POS_W > OUT_W) ? POS_W : OUT_W;
  localparam int SUM_W = PIX_W + 2;
  localparam logic [POS_W-1:0] POS_LAST = POS_W'(LINE_BYTES - 1);

  // Configuration registers
  logic [VIEW_W-1:0]  viewport_width;
  logic [SPACE_W-1:0] space_width;

  // Line state
  logic [POS_W-1:0] byte_position;
  logic [POS_W-1:0] current_line_start;
  logic [POS_W-1:0] content_end;
  logic [POS_W-1:0] piece_start;
  logic [PIX_W-1:0] line_pixels;
  logic [PIX_W-1:0] word_pixels;
  logic             line_has_word;
  logic             inside_word;

  logic [POS_W-1:0] byte_position_next;
  logic [POS_W-1:0] current_line_start_next;
  logic [POS_W-1:0] content_end_next;
  logic [POS_W-1:0] piece_start_next;
  logic [PIX_W-1:0] line_pixels_next;
  logic [PIX_W-1:0] word_pixels_next;
  logic             line_has_word_next;
  logic             inside_word_next;

  // Result queue
  res_t              queue [QUEUE_DEPTH];
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W-1:0] wr_ptr;
  logic [QCNT_W-1:0] count;

  logic src_take;
  logic res_take;
  logic [1:0] push_n;
  res_t push0;
  res_t push1;

  // Work signals of the step logic
  logic             is_space;
  logic             boundary;
  logic             split_line;
  logic             split_word;
  logic [POS_W-1:0] ws0;
  logic [PIX_W-1:0] wp0;
  logic [POS_W-1:0] cls1;
  logic             has1;
  logic [SUM_W-1:0] fit_sum;
  logic [SUM_W-1:0] word_sum;
  logic [SUM_W-1:0] commit_sum;
  logic [PIX_W-1:0] commit_pixels;
  logic [POS_W-1:0] eol_len;
  logic [EXT_W-1:0] ext_a_start;
  logic [EXT_W-1:0] ext_a_len;
  logic [EXT_W-1:0] ext_b_start;
  logic [EXT_W-1:0] ext_b_len;
  logic [EXT_W-1:0] ext_e_len;

  assign cfg_ready = 1'b1;
  assign src_stall = (count > QCNT_W'(QUEUE_DEPTH - 2));
  assign src_take  = src_valid && !src_stall;
  assign res_valid = (count != '0);
  assign res_take  = res_valid && !res_stall;

  assign line_offset  = queue[rd_ptr].start;
  assign line_length  = queue[rd_ptr].length;
  assign last_of_line = queue[rd_ptr].last;

  // Width of the open line plus a gap plus the scanned word, used on commit
  assign commit_sum = SUM_W'(line_pixels) + SUM_W'(space_width) + SUM_W'(word_pixels);
  assign commit_pixels = !line_has_word ? word_pixels :
                         (commit_sum > SUM_W'(PIX_MAX)) ? PIX_MAX : commit_sum[PIX_W-1:0];

  // Start of a word piece and its width so far
  assign is_space = (char_byte == SPACE_CHAR);
  assign boundary = !inside_word || ((char_byte & CONT_MASK) != CONT_TAG);
  assign ws0 = inside_word ? piece_start : byte_position;
  assign wp0 = inside_word ? word_pixels : '0;

  // Break before the word when it no longer fits behind the open line
  assign fit_sum = SUM_W'(line_pixels) + SUM_W'(space_width) + SUM_W'(wp0) +
                   SUM_W'(advance);
  assign split_line = boundary && line_has_word && (fit_sum > SUM_W'(viewport_width));
  assign cls1 = split_line ? ws0 : current_line_start;
  assign has1 = split_line ? 1'b0 : line_has_word;

  // Split an oversized word at this codepoint
  assign word_sum = SUM_W'(wp0) + SUM_W'(advance);
  assign split_word = boundary && !has1 && (byte_position > ws0) &&
                      (word_sum > SUM_W'(viewport_width));

  // Length of the closing line at end of source line
  assign eol_len = inside_word ? (byte_position - current_line_start) :
                   line_has_word ? (content_end - current_line_start) : '0;

  assign ext_a_start = EXT_W'(current_line_start);
  assign ext_a_len   = EXT_W'(content_end - current_line_start);
  assign ext_b_start = EXT_W'(cls1);
  assign ext_b_len   = EXT_W'(byte_position - cls1);
  assign ext_e_len   = EXT_W'(eol_len);

  // Step the line state for one source word
  always_comb begin
    byte_position_next      = byte_position;
    current_line_start_next = current_line_start;
    content_end_next        = content_end;
    piece_start_next        = piece_start;
    line_pixels_next        = line_pixels;
    word_pixels_next        = word_pixels;
    line_has_word_next      = line_has_word;
    inside_word_next        = inside_word;
    push_n = 2'd0;
    push0  = '{start: ext_a_start[OUT_W-1:0], length: ext_a_len[OUT_W-1:0], last: 1'b0};
    push1  = '{start: ext_b_start[OUT_W-1:0], length: ext_b_len[OUT_W-1:0], last: 1'b0};

    if (kind == KIND_EOL) begin
      // Close the source line and clear everything
      push_n = 2'd1;
      push0  = '{start: ext_a_start[OUT_W-1:0], length: ext_e_len[OUT_W-1:0], last: 1'b1};
      byte_position_next      = '0;
      current_line_start_next = '0;
      content_end_next        = '0;
      piece_start_next        = '0;
      line_pixels_next        = '0;
      word_pixels_next        = '0;
      line_has_word_next      = 1'b0;
      inside_word_next        = 1'b0;
    end else if (byte_position < POS_LAST) begin
      byte_position_next = byte_position + POS_W'(1);
      if (is_space) begin
        // Commit the word that the space ends
        if (inside_word) begin
          line_pixels_next   = commit_pixels;
          line_has_word_next = 1'b1;
          content_end_next   = byte_position;
          inside_word_next   = 1'b0;
        end
      end else begin
        inside_word_next        = 1'b1;
        piece_start_next        = split_word ? byte_position : ws0;
        current_line_start_next = split_word ? byte_position : cls1;
        line_has_word_next      = has1;
        line_pixels_next        = split_line ? '0 : line_pixels;
        word_pixels_next        = split_word ? PIX_W'(advance) :
                                  (word_sum > SUM_W'(PIX_MAX)) ? PIX_MAX :
                                  word_sum[PIX_W-1:0];
        // Compact the results into the queue slots
        if (split_line && split_word) begin
          push_n = 2'd2;
        end else if (split_line) begin
          push_n = 2'd1;
        end else if (split_word) begin
          push_n = 2'd1;
          push0  = push1;
        end
      end
    end
  end

  // Hold configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      viewport_width <= VIEW_RESET;
      space_width    <= SPACE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_VIEWPORT: viewport_width <= cfg_data[VIEW_W-1:0];
        CFG_SPACE:    space_width    <= cfg_data[SPACE_W-1:0];
        default:      ;
      endcase
    end
  end

  // Advance the line state on each accepted word
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position      <= '0;
      current_line_start <= '0;
      content_end        <= '0;
      piece_start        <= '0;
      line_pixels        <= '0;
      word_pixels        <= '0;
      line_has_word      <= 1'b0;
      inside_word        <= 1'b0;
    end else if (src_take) begin
      byte_position      <= byte_position_next;
      current_line_start <= current_line_start_next;
      content_end        <= content_end_next;
      piece_start        <= piece_start_next;
      line_pixels        <= line_pixels_next;
      word_pixels        <= word_pixels_next;
      line_has_word      <= line_has_word_next;
      inside_word        <= inside_word_next;
    end
  end

  // Write results into the queue
  always_ff @(posedge clk) begin
    if (src_take && (push_n != 2'd0)) begin
      queue[wr_ptr] <= push0;
    end
    if (src_take && (push_n == 2'd2)) begin
      queue[wr_ptr + QPTR_W'(1)] <= push1;
    end
  end

  // Track queue pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= '0;
      wr_ptr <= '0;
      count  <= '0;
    end else begin
      if (src_take) begin
        wr_ptr <= wr_ptr + QPTR_W'(push_n);
      end
      if (res_take) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      count <= count + (src_take ? QCNT_W'(push_n) : '0) - QCNT_W'(res_take);
    end
  end

endmodule

### test/tb.sv
// Self-checking testbench for the greedy word wrap breaker.
module tb;
  import gww_pkg::*;

  localparam int TEXT_BYTES  = 1024;
  localparam int STALL_LIMIT = 5000;
  localparam int RANDOM_ITEMS = 200;

  typedef struct packed {
    logic              kind;
    logic [BYTE_W-1:0] char_byte;
    logic [ADV_W-1:0]  advance;
  } src_word_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 src_valid = 1'b0;
  logic                 src_stall;
  logic                 kind = KIND_TEXT;
  logic [BYTE_W-1:0]    char_byte = '0;
  logic [ADV_W-1:0]     advance = '0;
  logic                 res_valid;
  logic                 res_stall = 1'b0;
  logic [OUT_W-1:0]     line_offset;
  logic [OUT_W-1:0]     line_length;
  logic                 last_of_line;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [31:0]          cfg_data = '0;

  greedy_word_wrap_breaker #(.LINE_BYTES(TEXT_BYTES)) dut (
    .clk(clk), .rst(rst),
    .src_valid(src_valid), .src_stall(src_stall),
    .kind(kind), .char_byte(char_byte), .advance(advance),
    .res_valid(res_valid), .res_stall(res_stall),
    .line_offset(line_offset), .line_length(line_length), .last_of_line(last_of_line),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // Source words waiting to be sent, display lines waiting to come out
  src_word_t   source_bytes[$];
  res_t        lines_due[$];
  int unsigned items_queued = 0;
  int          mismatches = 0;

  // Wrap state of the open source line and shadow registers
  logic [VIEW_W-1:0]  view_w = VIEW_RESET;
  logic [SPACE_W-1:0] space_w = SPACE_RESET;
  int unsigned byte_pos = 0;
  int unsigned cur_start = 0;
  int unsigned content_end = 0;
  int unsigned piece_start = 0;
  int unsigned line_px = 0;
  int unsigned word_px = 0;
  bit          line_has_word = 1'b0;
  bit          in_word = 1'b0;

  // Sender burst shaping and receiver stall pattern
  int burst_left = 0;
  int gap_left = 0;
  int stall_mode = 0;
  int stall_left = 0;
  int stall_tick = 0;
  int idle_cycles = 0;

  initial begin
    forever #1 clk = ~clk;
  end

  function automatic int unsigned clip_px(input int unsigned v);
    return (v > PIX_MAX) ? PIX_MAX : v;
  endfunction

  task automatic post_line(input int unsigned s, input int unsigned len, input logic last);
    res_t r;
    r.start  = s[OUT_W-1:0];
    r.length = len[OUT_W-1:0];
    r.last   = last;
    lines_due.push_back(r);
  endtask

  // Fold the finished word or word piece into the open line
  task automatic close_word(input int unsigned end_pos);
    if (line_has_word) line_px = clip_px(line_px + space_w + word_px);
    else line_px = word_px;
    line_has_word = 1'b1;
    content_end = end_pos;
    in_word = 1'b0;
  endtask

  // Advance the wrap state by one accepted word and post the lines it closes
  task automatic wrap_word(input logic k, input logic [BYTE_W-1:0] b,
                           input logic [ADV_W-1:0] adv);
    int unsigned pos;
    bit split_ok;
    pos = byte_pos;
    if (k == KIND_EOL) begin
      if (in_word) close_word(pos);
      post_line(cur_start, line_has_word ? content_end - cur_start : 0, 1'b1);
      byte_pos = 0;
      cur_start = 0;
      content_end = 0;
      piece_start = 0;
      line_px = 0;
      word_px = 0;
      line_has_word = 1'b0;
      in_word = 1'b0;
    end else if (pos < TEXT_BYTES - 1) begin
      byte_pos = pos + 1;
      if (b == SPACE_CHAR) begin
        if (in_word) close_word(pos);
      end else begin
        split_ok = !in_word || ((b & CONT_MASK) != CONT_TAG);
        if (!in_word) begin
          in_word = 1'b1;
          piece_start = pos;
          word_px = 0;
        end
        if (split_ok) begin
          // wrap before the word when it no longer fits beside the open line
          if (line_has_word && line_px + space_w + word_px + adv > view_w) begin
            post_line(cur_start, content_end - cur_start, 1'b0);
            cur_start = piece_start;
            line_has_word = 1'b0;
            line_px = 0;
          end
          // split an oversized word at this codepoint
          if (!line_has_word && pos > piece_start && word_px + adv > view_w) begin
            post_line(cur_start, pos - cur_start, 1'b0);
            cur_start = pos;
            piece_start = pos;
            word_px = 0;
          end
        end
        word_px = clip_px(word_px + adv);
      end
    end
  endtask

  // Drive source words, in bursts with random gaps
  always @(posedge clk) begin : drive_src
    src_word_t w;
    if (rst) begin
      src_valid <= 1'b0;
    end else begin
      if (src_valid && !src_stall) wrap_word(kind, char_byte, advance);
      if (!src_valid || !src_stall) begin
        if (gap_left > 0 || source_bytes.size() == 0) begin
          if (gap_left > 0) gap_left--;
          src_valid <= 1'b0;
        end else begin
          w = source_bytes.pop_front();
          src_valid <= 1'b1;
          kind      <= w.kind;
          char_byte <= w.char_byte;
          advance   <= w.advance;
          if (burst_left > 0) burst_left--;
          if (burst_left == 0) begin
            if ($urandom_range(0, 3) == 0) begin
              burst_left = $urandom_range(50, 300);
              gap_left = 0;
            end else begin
              burst_left = $urandom_range(1, 20);
              gap_left = $urandom_range(1, 10);
            end
          end
        end
      end
    end
  end

  // Stall the result side on a pattern that changes now and then
  always @(posedge clk) begin
    if (rst) begin
      res_stall <= 1'b0;
    end else begin
      stall_tick++;
      if (stall_left == 0) begin
        stall_mode = $urandom_range(0, 4);
        stall_left = $urandom_range(20, 200);
      end else begin
        stall_left--;
      end
      case (stall_mode)
        0: res_stall <= 1'b0;
        1: res_stall <= ($urandom_range(0, 3) == 0);
        2: res_stall <= ($urandom_range(0, 1) == 0);
        3: res_stall <= ((stall_tick % 5) < 3);
        default: res_stall <= ((stall_tick % 16) < 12);
      endcase
    end
  end

  // Check each display line against the oldest one due
  always @(posedge clk) begin : check_lines
    res_t want;
    if (!rst && res_valid && !res_stall) begin
      if (lines_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("tb: unexpected line start=%0d length=%0d last=%0b",
                   line_offset, line_length, last_of_line);
      end else begin
        want = lines_due.pop_front();
        if (want.start !== line_offset || want.length !== line_length ||
            want.last !== last_of_line) begin
          mismatches++;
          if (mismatches <= 10)
            $display("tb: line mismatch: expected start=%0d length=%0d last=%0b, got %0d %0d %0b",
                     want.start, want.length, want.last,
                     line_offset, line_length, last_of_line);
        end
      end
    end
  end

  // End the run when nothing moves for too long
  always @(posedge clk) begin
    if (rst || (src_valid && !src_stall) || (res_valid && !res_stall) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == STALL_LIMIT) begin
      $display("tb: done, errors");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic queue_byte(input logic k, input logic [BYTE_W-1:0] b,
                            input logic [ADV_W-1:0] a);
    src_word_t w;
    w.kind = k;
    w.char_byte = b;
    w.advance = a;
    source_bytes.push_back(w);
    items_queued++;
  endtask

  task automatic queue_space();
    queue_byte(KIND_TEXT, SPACE_CHAR, 8'($urandom));
  endtask

  // One UTF-8 codepoint: lead byte carries the advance, continuations carry zero
  task automatic queue_codepoint(input int unsigned adv_hi);
    int unsigned nb;
    logic [BYTE_W-1:0] lead;
    nb = ($urandom_range(0, 2) != 0) ? 1 : $urandom_range(2, 4);
    case (nb)
      1: lead = 8'($urandom_range(8'h21, 8'h7E));
      2: lead = 8'($urandom_range(8'hC2, 8'hDF));
      3: lead = 8'($urandom_range(8'hE0, 8'hEF));
      default: lead = 8'($urandom_range(8'hF0, 8'hF4));
    endcase
    queue_byte(KIND_TEXT, lead, 8'($urandom_range(0, adv_hi)));
    repeat (nb - 1) queue_byte(KIND_TEXT, 8'(8'h80 | $urandom_range(0, 63)), 8'h00);
  endtask

  // One source line of words; noisy lines mix in arbitrary bytes
  task automatic queue_line(input int unsigned n_words, input int unsigned min_bytes,
                            input int unsigned adv_hi, input bit noisy);
    int unsigned first;
    int unsigned nw;
    int unsigned cps;
    first = items_queued;
    nw = 0;
    if ($urandom_range(0, 3) == 0) repeat ($urandom_range(1, 3)) queue_space();
    while (nw < n_words || items_queued - first < min_bytes) begin
      if (nw != 0) repeat ($urandom_range(1, 3)) queue_space();
      cps = ($urandom_range(0, 7) == 0) ? $urandom_range(8, 30) : $urandom_range(1, 6);
      repeat (cps) begin
        if (noisy && $urandom_range(0, 5) == 0)
          queue_byte(KIND_TEXT, 8'($urandom), 8'($urandom));
        else
          queue_codepoint(adv_hi);
      end
      nw++;
    end
    if ($urandom_range(0, 2) == 0) repeat ($urandom_range(1, 3)) queue_space();
    queue_byte(KIND_EOL, 8'($urandom), 8'($urandom));
  endtask

  // Hold until every queued word is taken and every line has come out
  task automatic wait_idle();
    while (source_bytes.size() != 0 || src_valid || lines_due.size() != 0)
      @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    if (idx == CFG_VIEWPORT) view_w = val[VIEW_W-1:0];
    else space_w = val[SPACE_W-1:0];
    @(negedge clk);
  endtask

  // Drain, reprogram both registers, then queue a batch of lines
  task automatic run_phase(input logic [31:0] view, input logic [31:0] space,
                           input int unsigned adv_hi, input int unsigned n_lines);
    wait_idle();
    repeat (4) @(negedge clk);
    write_reg(CFG_VIEWPORT, view);
    write_reg(CFG_SPACE, space);
    repeat (n_lines)
      queue_line(($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 8), 0, adv_hi,
                 ($urandom_range(0, 3) == 0));
  endtask

  initial begin : stimulus
    int unsigned base;
    int unsigned view;
    int unsigned adv_hi;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // empty line, junk on the end-of-line fields
    queue_byte(KIND_EOL, 8'hFF, 8'hFF);
    // all spaces; the space advance is ignored
    queue_byte(KIND_TEXT, SPACE_CHAR, 8'hFF);
    queue_byte(KIND_TEXT, SPACE_CHAR, 8'h00);
    queue_byte(KIND_EOL, 8'h00, 8'h00);
    // NUL byte as a one-byte word
    queue_byte(KIND_TEXT, 8'h00, 8'h00);
    queue_byte(KIND_EOL, 8'h00, 8'h00);
    // leading spaces, then a first word too wide for the viewport
    queue_byte(KIND_TEXT, SPACE_CHAR, 8'h10);
    queue_byte(KIND_TEXT, SPACE_CHAR, 8'h00);
    queue_byte(KIND_TEXT, 8'h61, 8'hFF);
    queue_byte(KIND_TEXT, 8'h62, 8'hFF);
    queue_byte(KIND_EOL, 8'h00, 8'h00);
    // three-byte codepoints: no split inside a codepoint
    queue_byte(KIND_TEXT, 8'hE2, 8'hFA);
    queue_byte(KIND_TEXT, 8'h82, 8'h00);
    queue_byte(KIND_TEXT, 8'hAC, 8'h00);
    queue_byte(KIND_TEXT, 8'hE2, 8'hFA);
    queue_byte(KIND_TEXT, 8'h82, 8'h00);
    queue_byte(KIND_TEXT, 8'hAC, 8'h00);
    queue_byte(KIND_EOL, 8'h00, 8'h00);
    // two words fit, the third wraps after a run of spaces
    queue_byte(KIND_TEXT, 8'h78, 8'hC8);
    queue_byte(KIND_TEXT, SPACE_CHAR, 8'h00);
    queue_byte(KIND_TEXT, 8'h79, 8'hC8);
    queue_byte(KIND_TEXT, SPACE_CHAR, 8'h00);
    queue_byte(KIND_TEXT, SPACE_CHAR, 8'h00);
    queue_byte(KIND_TEXT, 8'h7A, 8'h64);
    queue_byte(KIND_EOL, 8'h00, 8'h00);

    // overlong source line: bytes past the store are dropped
    run_phase(32'd60, 32'd4, 12, 0);
    queue_line(0, TEXT_BYTES + 4, 12, 1'b0);

    base = items_queued;
    // extremes of both registers, then a zero viewport
    run_phase(32'd10, 32'd0, 6, 2);
    run_phase(32'd4095, 32'd255, 255, 2);
    run_phase(32'd0, 32'd8, 10, 2);
    while (items_queued - base < RANDOM_ITEMS) begin
      view = ($urandom_range(0, 1) == 0) ? $urandom_range(10, 300) : $urandom_range(10, 4095);
      adv_hi = view / $urandom_range(3, 10);
      if (adv_hi > 255 || $urandom_range(0, 7) == 0) adv_hi = 255;
      if (adv_hi == 0) adv_hi = 1;
      run_phase({20'($urandom), 12'(view)}, {24'($urandom), 8'($urandom)}, adv_hi,
                $urandom_range(2, 4));
    end

    wait_idle();
    repeat (20) @(negedge clk);
    mismatches += lines_due.size();
    if (mismatches == 0) $display("tb: done, clean");
    else $display("tb: done, errors");
    $finish;
  end

endmodule

### greedy_word_wrap_breaker.f
rtl/gww_pkg.sv
rtl/greedy_word_wrap_breaker.sv
test/tb.sv
